>>> hdl/pac_pkg.sv
// Shared types and constants for the polygon area and y extremes block.
package pac_pkg;

    localparam int COORD_BITS = 24;
    localparam int TERM_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * TERM_BITS;
    localparam int SUM_BITS = 62;
    localparam int AREA_BITS = 61;
    localparam int COUNT_BITS = 11;
    localparam int INDEX_BITS = 10;

    localparam logic [COUNT_BITS-1:0] MAX_POINTS = 11'd1024;
    localparam logic [COUNT_BITS-1:0] MIN_AREA_POINTS = 11'd3;

    localparam int MID_DEPTH = 4;
    localparam int MID_PTR_BITS = $clog2(MID_DEPTH);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);

    typedef struct packed {
        logic [COUNT_BITS-1:0]        vertex_count;
        logic [INDEX_BITS-1:0]        min_y_index;
        logic signed [COORD_BITS-1:0] min_y_value;
        logic [INDEX_BITS-1:0]        max_y_index;
        logic signed [COORD_BITS-1:0] max_y_value;
        logic                         count_overflow;
    } summary_t;

    typedef struct packed {
        logic signed [TERM_BITS-1:0] dx_step;
        logic signed [TERM_BITS-1:0] sy_step;
        logic signed [TERM_BITS-1:0] dx_close;
        logic signed [TERM_BITS-1:0] sy_close;
        logic                        close;
        logic                        zero_area;
        summary_t                    meta;
    } term_job_t;

    typedef struct packed {
        logic [AREA_BITS-1:0] double_area;
        summary_t             meta;
    } result_t;

endpackage

>>> hdl/pac_front.sv
// Front end: accepts vertices, tracks extremes and count, and issues shoelace term jobs.
module pac_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [pac_pkg::COORD_BITS-1:0] x_coord,
    input  logic signed [pac_pkg::COORD_BITS-1:0] y_coord,
    input  logic                                  last_vertex,
    output logic                                  job_push,
    output pac_pkg::term_job_t                    job,
    input  logic                                  job_full
);

    logic signed [pac_pkg::COORD_BITS-1:0] first_x_reg, first_x_next;
    logic signed [pac_pkg::COORD_BITS-1:0] first_y_reg, first_y_next;
    logic signed [pac_pkg::COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic signed [pac_pkg::COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic signed [pac_pkg::COORD_BITS-1:0] low_y_reg, low_y_next;
    logic signed [pac_pkg::COORD_BITS-1:0] high_y_reg, high_y_next;
    logic [pac_pkg::INDEX_BITS-1:0]        low_index_reg, low_index_next;
    logic [pac_pkg::INDEX_BITS-1:0]        high_index_reg, high_index_next;
    logic [pac_pkg::COUNT_BITS-1:0]        seen_count_reg, seen_count_next;
    logic                                  overflowed_reg, overflowed_next;
    logic                                  accept;

    assign full = job_full;
    assign accept = push && !job_full;
    assign job_push = accept;

    always_comb
    begin
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        low_y_next = low_y_reg;
        high_y_next = high_y_reg;
        low_index_next = low_index_reg;
        high_index_next = high_index_reg;
        seen_count_next = seen_count_reg;
        overflowed_next = overflowed_reg;
        job.dx_step = '0;
        job.sy_step = '0;

        if (seen_count_reg >= pac_pkg::MAX_POINTS)
        begin
            overflowed_next = 1'b1;
        end
        else if (seen_count_reg == '0)
        begin
            first_x_next = x_coord;
            first_y_next = y_coord;
            prev_x_next = x_coord;
            prev_y_next = y_coord;
            low_y_next = y_coord;
            high_y_next = y_coord;
            low_index_next = '0;
            high_index_next = '0;
            seen_count_next = pac_pkg::COUNT_BITS'(1);
        end
        else
        begin
            job.dx_step = {prev_x_reg[pac_pkg::COORD_BITS-1], prev_x_reg}
                        - {x_coord[pac_pkg::COORD_BITS-1], x_coord};
            job.sy_step = {prev_y_reg[pac_pkg::COORD_BITS-1], prev_y_reg}
                        + {y_coord[pac_pkg::COORD_BITS-1], y_coord};
            if (y_coord < low_y_reg)
            begin
                low_y_next = y_coord;
                low_index_next = seen_count_reg[pac_pkg::INDEX_BITS-1:0];
            end
            if (y_coord > high_y_reg)
            begin
                high_y_next = y_coord;
                high_index_next = seen_count_reg[pac_pkg::INDEX_BITS-1:0];
            end
            prev_x_next = x_coord;
            prev_y_next = y_coord;
            seen_count_next = seen_count_reg + 1'b1;
        end

        job.dx_close = {prev_x_next[pac_pkg::COORD_BITS-1], prev_x_next}
                     - {first_x_next[pac_pkg::COORD_BITS-1], first_x_next};
        job.sy_close = {prev_y_next[pac_pkg::COORD_BITS-1], prev_y_next}
                     + {first_y_next[pac_pkg::COORD_BITS-1], first_y_next};
        job.close = last_vertex;
        job.zero_area = seen_count_next < pac_pkg::MIN_AREA_POINTS;
        job.meta.vertex_count = seen_count_next;
        job.meta.min_y_index = low_index_next;
        job.meta.min_y_value = low_y_next;
        job.meta.max_y_index = high_index_next;
        job.meta.max_y_value = high_y_next;
        job.meta.count_overflow = overflowed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            low_y_reg <= '0;
            high_y_reg <= '0;
            low_index_reg <= '0;
            high_index_reg <= '0;
            seen_count_reg <= '0;
            overflowed_reg <= 1'b0;
        end
        else if (accept && last_vertex)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            low_y_reg <= '0;
            high_y_reg <= '0;
            low_index_reg <= '0;
            high_index_reg <= '0;
            seen_count_reg <= '0;
            overflowed_reg <= 1'b0;
        end
        else if (accept)
        begin
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
            low_y_reg <= low_y_next;
            high_y_reg <= high_y_next;
            low_index_reg <= low_index_next;
            high_index_reg <= high_index_next;
            seen_count_reg <= seen_count_next;
            overflowed_reg <= overflowed_next;
        end
    end

endmodule

>>> hdl/pac_mid_fifo.sv
// Short queue of term jobs between the front end and the arithmetic back end.
module pac_mid_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pac_pkg::term_job_t din,
    output logic               full,
    input  logic               pop,
    output pac_pkg::term_job_t dout,
    output logic               empty
);

    pac_pkg::term_job_t                mem_reg [pac_pkg::MID_DEPTH];
    logic [pac_pkg::MID_PTR_BITS-1:0]  wr_ptr_reg;
    logic [pac_pkg::MID_PTR_BITS-1:0]  rd_ptr_reg;
    logic [pac_pkg::MID_PTR_BITS:0]    count_reg;
    logic                              do_push;
    logic                              do_pop;

    assign full = count_reg == (pac_pkg::MID_PTR_BITS+1)'(pac_pkg::MID_DEPTH);
    assign empty = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign dout = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/pac_back.sv
// Back end: multiplies term jobs, accumulates the shoelace sum and queues results.
module pac_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pac_pkg::term_job_t                    job,
    input  logic                                  job_empty,
    output logic                                  job_pop,
    output logic                                  empty,
    input  logic                                  pop,
    output pac_pkg::result_t                      result
);

    localparam int EXT_BITS = pac_pkg::SUM_BITS - pac_pkg::PROD_BITS;
    localparam int CNT_BITS = pac_pkg::OUT_PTR_BITS + 2;

    logic signed [pac_pkg::PROD_BITS-1:0] prod_step;
    logic signed [pac_pkg::PROD_BITS-1:0] prod_close;
    logic signed [pac_pkg::PROD_BITS-1:0] pa_reg;
    logic signed [pac_pkg::PROD_BITS-1:0] pb_reg;
    logic                                 m_valid_reg;
    logic                                 m_close_reg;
    logic                                 m_zero_reg;
    pac_pkg::summary_t                    m_meta_reg;

    logic [pac_pkg::SUM_BITS-1:0]         acc_reg, acc_next;
    logic [pac_pkg::SUM_BITS-1:0]         sum;
    logic [pac_pkg::SUM_BITS-1:0]         close_ext;
    logic [pac_pkg::SUM_BITS-1:0]         a_sum_reg;
    logic                                 a_valid_reg;
    logic                                 a_zero_reg;
    pac_pkg::summary_t                    a_meta_reg;
    logic [pac_pkg::SUM_BITS-1:0]         magnitude;
    pac_pkg::result_t                     out_din;

    pac_pkg::result_t                     out_mem_reg [pac_pkg::OUT_DEPTH];
    logic [pac_pkg::OUT_PTR_BITS-1:0]     out_wr_ptr_reg;
    logic [pac_pkg::OUT_PTR_BITS-1:0]     out_rd_ptr_reg;
    logic [pac_pkg::OUT_PTR_BITS:0]       out_count_reg;
    logic [CNT_BITS-1:0]                  committed;
    logic                                 out_pop;

    // A closing job only enters once a result slot is reserved for it.
    assign committed = CNT_BITS'(out_count_reg) + CNT_BITS'(m_valid_reg && m_close_reg)
                     + CNT_BITS'(a_valid_reg);
    assign job_pop = !job_empty
                  && (!job.close || committed < CNT_BITS'(pac_pkg::OUT_DEPTH));

    assign prod_step = job.dx_step * job.sy_step;
    assign prod_close = job.dx_close * job.sy_close;

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            pa_reg <= prod_step;
            pb_reg <= prod_close;
            m_close_reg <= job.close;
            m_zero_reg <= job.zero_area;
            m_meta_reg <= job.meta;
        end
    end

    always_comb
    begin
        close_ext = m_close_reg ? {{EXT_BITS{pb_reg[pac_pkg::PROD_BITS-1]}}, pb_reg} : '0;
        sum = acc_reg + {{EXT_BITS{pa_reg[pac_pkg::PROD_BITS-1]}}, pa_reg} + close_ext;
        acc_next = acc_reg;
        if (m_valid_reg)
        begin
            acc_next = m_close_reg ? '0 : sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_valid_reg && m_close_reg)
        begin
            a_sum_reg <= sum;
            a_zero_reg <= m_zero_reg;
            a_meta_reg <= m_meta_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            m_valid_reg <= job_pop;
            a_valid_reg <= m_valid_reg && m_close_reg;
            acc_reg <= acc_next;
        end
    end

    assign magnitude = a_sum_reg[pac_pkg::SUM_BITS-1] ? (~a_sum_reg + 1'b1) : a_sum_reg;
    assign out_din.double_area = a_zero_reg ? '0 : magnitude[pac_pkg::AREA_BITS-1:0];
    assign out_din.meta = a_meta_reg;

    assign empty = out_count_reg == '0;
    assign out_pop = pop && !empty;
    assign result = out_mem_reg[out_rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            out_mem_reg[out_wr_ptr_reg] <= out_din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (a_valid_reg)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            end
            if (a_valid_reg && !out_pop)
            begin
                out_count_reg <= out_count_reg + 1'b1;
            end
            else if (out_pop && !a_valid_reg)
            begin
                out_count_reg <= out_count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/polygon_area_and_y_extremes.sv
// Top level of the polygon area and y extremes block.
//
// Vertices enter through a queue-style port: a beat is taken at a rising edge
// with push high and full low. Each beat carries x_coord, y_coord and
// last_vertex; the beat with last_vertex high closes the polygon.
// One result per polygon leaves through a second queue-style port: while empty
// is low the oldest result sits on the result ports, and a beat is taken at a
// rising edge with pop high and empty low.
// The block takes one vertex per cycle while full is low. The front end
// updates the vertex state in the cycle of the beat and queues a job holding
// the step term and closing term operands; the back end multiplies both terms
// in one stage and adds them to the 62-bit sum in the next.
// The sum for a closing job is registered before it enters the result queue.
// Reset clears all vertex state and empties both queues.
// When the receiver stops popping, the four-entry result queue fills, the back
// end stops taking closing jobs, the four-entry job queue fills and full rises.
module polygon_area_and_y_extremes (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [pac_pkg::COORD_BITS-1:0]  x_coord,
    input  logic signed [pac_pkg::COORD_BITS-1:0]  y_coord,
    input  logic                                   last_vertex,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [pac_pkg::AREA_BITS-1:0]          double_area,
    output logic [pac_pkg::COUNT_BITS-1:0]         vertex_count,
    output logic [pac_pkg::INDEX_BITS-1:0]         min_y_index,
    output logic signed [pac_pkg::COORD_BITS-1:0]  min_y_value,
    output logic [pac_pkg::INDEX_BITS-1:0]         max_y_index,
    output logic signed [pac_pkg::COORD_BITS-1:0]  max_y_value,
    output logic                                   count_overflow
);

    logic               job_push;
    logic               job_full;
    logic               job_pop;
    logic               job_empty;
    pac_pkg::term_job_t job_in;
    pac_pkg::term_job_t job_out;
    pac_pkg::result_t   result;

    pac_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .last_vertex (last_vertex),
        .job_push    (job_push),
        .job         (job_in),
        .job_full    (job_full)
    );

    pac_mid_fifo u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (job_out),
        .empty (job_empty)
    );

    pac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    assign double_area = result.double_area;
    assign vertex_count = result.meta.vertex_count;
    assign min_y_index = result.meta.min_y_index;
    assign min_y_value = result.meta.min_y_value;
    assign max_y_index = result.meta.max_y_index;
    assign max_y_value = result.meta.max_y_value;
    assign count_overflow = result.meta.count_overflow;

endmodule
